@@ rtl/fwrl_pkg.sv @@
// Shared constants, codes and types of the per-key fixed-window rate limiter.
package fwrl_pkg;

   // Parameter defaults
   localparam int MAX_PRINCIPALS_DEF = 64;
   localparam int KEY_WIDTH_DEF      = 32;
   localparam int TIME_WIDTH_DEF     = 32;

   // Fixed field widths
   localparam int COUNT_W    = 16;
   localparam int LIMIT_W    = 16;
   localparam int WTICK_W    = 32;
   localparam int REASON_W   = 2;
   localparam int OUT_CNT_W  = 7;
   localparam int RSP_DATA_W = 16;

   localparam logic [WTICK_W-1:0] WINDOW_TICKS_RESET = 32'd60000;
   localparam logic [COUNT_W-1:0] COUNT_MAX          = 16'hFFFF;

   // Item kinds
   localparam logic KIND_CHARGE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Refusal reasons
   localparam logic [REASON_W-1:0] REASON_OK        = 2'd0;
   localparam logic [REASON_W-1:0] REASON_REQ_QUOTA = 2'd1;
   localparam logic [REASON_W-1:0] REASON_TOOL_QUOTA = 2'd2;

   // Flags of the scan token that walks down the cell row
   typedef struct packed {
      logic active;
      logic found;
      logic free_found;
      logic victim_valid;
   } scan_flags_type;

   // Table write command broadcast to every cell
   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } cell_cmd_type;

endpackage

@@ rtl/per_key_fixed_window_rate_limiter.sv @@
// Top level of the per-key fixed-window rate limiter: control, decision and cell row.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tuser kind, tdata charge fields
//   rsp      out        rsp_tvalid/rsp_tready   tdata allowed, reason, tracked_count
//   csr      in         csr_valid/csr_ready     csr_data window_ticks
//
// A charge that is checked goes from acceptance to the result register through the
// launch register, the cell row, which the lookup token walks one cell per cycle,
// the window check and the commit. A clear or a charge with both limits zero goes
// from acceptance straight to the commit state. Reset empties the table at once and
// sets window_ticks to 60000.
// A result that is not taken holds the commit; a new word is accepted while the
// previous result waits in the output register.
module per_key_fixed_window_rate_limiter #(
   parameter int MAX_PRINCIPALS = fwrl_pkg::MAX_PRINCIPALS_DEF,
   parameter int KEY_WIDTH      = fwrl_pkg::KEY_WIDTH_DEF,
   parameter int TIME_WIDTH     = fwrl_pkg::TIME_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // kind
   input  logic [0:0] req_tuser,
   // principal_key, now_time, is_tool_call, request_limit, tool_call_limit, zero pad
   input  logic [((KEY_WIDTH+TIME_WIDTH+1+2*fwrl_pkg::LIMIT_W+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // allowed, reason, tracked_count, zero pad
   output logic [fwrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [fwrl_pkg::WTICK_W-1:0] csr_data
);

   localparam int N      = MAX_PRINCIPALS;
   localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
   localparam int CNT_W  = $clog2(N + 1);
   localparam int CW     = fwrl_pkg::COUNT_W;
   localparam int LW     = fwrl_pkg::LIMIT_W;
   localparam int CMP_W  = (TIME_WIDTH > fwrl_pkg::WTICK_W) ? TIME_WIDTH : fwrl_pkg::WTICK_W;
   localparam int OW     = fwrl_pkg::OUT_CNT_W;
   localparam int RW     = fwrl_pkg::REASON_W;
   localparam int TIME_LO = KEY_WIDTH;
   localparam int TOOL_LO = TIME_LO + TIME_WIDTH;
   localparam int RLIM_LO = TOOL_LO + 1;
   localparam int TLIM_LO = RLIM_LO + LW;
   localparam int RSP_USED = 1 + RW + OW;
   localparam int RSP_DATA_W_LOCAL = fwrl_pkg::RSP_DATA_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_CHECK  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // Held item
   logic                 kind_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic                 tool_ff;
   logic [LW-1:0]        rlim_ff;
   logic [LW-1:0]        tlim_ff;
   logic                 bypass_ff;

   logic [fwrl_pkg::WTICK_W-1:0] wt_ff;
   logic [CNT_W-1:0]             tracked_ff, tracked_in;
   logic                         launch_ff;

   // Captured scan result
   fwrl_pkg::scan_flags_type scan_flags_ff;
   logic [IDX_W-1:0]         scan_found_ff, scan_free_ff, scan_victim_ff;
   logic [TIME_WIDTH-1:0]    scan_ws_ff;
   logic [CW-1:0]            scan_rc_ff, scan_tc_ff;

   // Check stage
   logic [IDX_W-1:0]      slot_ff;
   logic                  new_ff;
   logic                  restart_ff;
   logic [TIME_WIDTH-1:0] ws_ff;
   logic [CW-1:0]         rc_ff, tc_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W_LOCAL-1:0] rsp_data_ff;

   logic req_fire, rsp_free, commit_fire;
   logic is_clear, is_bypass;
   logic full;

   // Cell row wiring
   fwrl_pkg::scan_flags_type flags_c     [0:N];
   logic [IDX_W-1:0]         found_idx_c [0:N];
   logic [IDX_W-1:0]         free_idx_c  [0:N];
   logic [IDX_W-1:0]         victim_idx_c[0:N];
   logic [TIME_WIDTH-1:0]    best_age_c  [0:N];
   logic [TIME_WIDTH-1:0]    ws_c        [0:N];
   logic [CW-1:0]            rc_c        [0:N];
   logic [CW-1:0]            tc_c        [0:N];
   logic [N-1:0]             active_vec;

   fwrl_pkg::cell_cmd_type   cmd;
   logic [TIME_WIDTH-1:0]    wr_ws;
   logic [CW-1:0]            wr_rc, wr_tc;

   // Check-stage decision
   logic                  chk_new;
   logic [IDX_W-1:0]      chk_slot;
   logic [TIME_WIDTH-1:0] chk_ws;
   logic [TIME_WIDTH-1:0] chk_diff;
   logic                  chk_restart;

   // Commit-stage decision
   logic [CW-1:0]   rc_eff, tc_eff;
   logic [CW:0]     next_r, next_t;
   logic            allowed;
   logic [RW-1:0]   reason;
   logic [CNT_W+OW-1:0] count_ext;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign commit_fire = (state_ff == ST_COMMIT) && rsp_free;
   assign is_clear    = (req_tuser[0] == fwrl_pkg::KIND_CLEAR);
   assign is_bypass   = (req_tdata[RLIM_LO +: LW] == '0) && (req_tdata[TLIM_LO +: LW] == '0);
   assign full        = (tracked_ff == CNT_W'(N));

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff <= fwrl_pkg::WINDOW_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         wt_ff <= csr_data;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (is_clear || is_bypass) ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (flags_c[N].active) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= req_fire && !is_clear && !is_bypass;
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff   <= req_tuser[0];
         key_ff    <= req_tdata[0 +: KEY_WIDTH];
         now_ff    <= req_tdata[TIME_LO +: TIME_WIDTH];
         tool_ff   <= req_tdata[TOOL_LO];
         rlim_ff   <= req_tdata[RLIM_LO +: LW];
         tlim_ff   <= req_tdata[TLIM_LO +: LW];
         bypass_ff <= is_bypass;
      end
   end

   // Launch the token into the first cell
   always_comb begin
      flags_c[0]        = '0;
      flags_c[0].active = launch_ff;
      found_idx_c[0]    = '0;
      free_idx_c[0]     = '0;
      victim_idx_c[0]   = '0;
      best_age_c[0]     = '0;
      ws_c[0]           = '0;
      rc_c[0]           = '0;
      tc_c[0]           = '0;
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      fwrl_cell #(
         .KEY_W    (KEY_WIDTH),
         .TIME_W   (TIME_WIDTH),
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .key            (key_ff),
         .now            (now_ff),
         .cmd            (cmd),
         .wr_idx         (slot_ff),
         .wr_key         (key_ff),
         .wr_ws          (wr_ws),
         .wr_ls          (now_ff),
         .wr_rc          (wr_rc),
         .wr_tc          (wr_tc),
         .in_flags       (flags_c[g]),
         .in_found_idx   (found_idx_c[g]),
         .in_free_idx    (free_idx_c[g]),
         .in_victim_idx  (victim_idx_c[g]),
         .in_best_age    (best_age_c[g]),
         .in_ws          (ws_c[g]),
         .in_rc          (rc_c[g]),
         .in_tc          (tc_c[g]),
         .out_flags      (flags_c[g+1]),
         .out_found_idx  (found_idx_c[g+1]),
         .out_free_idx   (free_idx_c[g+1]),
         .out_victim_idx (victim_idx_c[g+1]),
         .out_best_age   (best_age_c[g+1]),
         .out_ws         (ws_c[g+1]),
         .out_rc         (rc_c[g+1]),
         .out_tc         (tc_c[g+1])
      );
      assign active_vec[g] = flags_c[g+1].active;
   end

   // Capture the token as it leaves the last cell
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && flags_c[N].active) begin
         scan_flags_ff  <= flags_c[N];
         scan_found_ff  <= found_idx_c[N];
         scan_free_ff   <= free_idx_c[N];
         scan_victim_ff <= victim_idx_c[N];
         scan_ws_ff     <= ws_c[N];
         scan_rc_ff     <= rc_c[N];
         scan_tc_ff     <= tc_c[N];
      end
   end

   // Pick the slot and test the window
   always_comb begin
      chk_new = !scan_flags_ff.found;
      if (scan_flags_ff.found) begin
         chk_slot = scan_found_ff;
      end else if (full) begin
         chk_slot = scan_victim_ff;
      end else begin
         chk_slot = scan_free_ff;
      end
      chk_ws      = chk_new ? now_ff : scan_ws_ff;
      chk_diff    = now_ff - chk_ws;
      chk_restart = CMP_W'(chk_diff) >= CMP_W'(wt_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         slot_ff    <= chk_slot;
         new_ff     <= chk_new;
         restart_ff <= chk_restart;
         ws_ff      <= chk_ws;
         rc_ff      <= chk_new ? '0 : scan_rc_ff;
         tc_ff      <= chk_new ? '0 : scan_tc_ff;
      end
   end

   // Admit or refuse, and build the entry update
   always_comb begin
      rc_eff = restart_ff ? '0 : rc_ff;
      tc_eff = restart_ff ? '0 : tc_ff;
      next_r = {1'b0, rc_eff} + (CW+1)'(1);
      next_t = {1'b0, tc_eff} + (CW+1)'(tool_ff);
      allowed = 1'b1;
      reason  = fwrl_pkg::REASON_OK;
      if (kind_ff == fwrl_pkg::KIND_CHARGE && !bypass_ff) begin
         if (rlim_ff != '0 && next_r > {1'b0, rlim_ff}) begin
            allowed = 1'b0;
            reason  = fwrl_pkg::REASON_REQ_QUOTA;
         end else if (tool_ff && tlim_ff != '0 && next_t > {1'b0, tlim_ff}) begin
            allowed = 1'b0;
            reason  = fwrl_pkg::REASON_TOOL_QUOTA;
         end
      end
      wr_ws = restart_ff ? now_ff : ws_ff;
      if (allowed) begin
         wr_rc = next_r[CW] ? fwrl_pkg::COUNT_MAX : next_r[CW-1:0];
         wr_tc = next_t[CW] ? fwrl_pkg::COUNT_MAX : next_t[CW-1:0];
      end else begin
         wr_rc = rc_eff;
         wr_tc = tc_eff;
      end
      cmd.clear_all = commit_fire && (kind_ff == fwrl_pkg::KIND_CLEAR);
      cmd.wr_en     = commit_fire && (kind_ff == fwrl_pkg::KIND_CHARGE) && !bypass_ff;
   end

   // Track the number of valid entries
   always_comb begin
      tracked_in = tracked_ff;
      if (cmd.clear_all) begin
         tracked_in = '0;
      end else if (cmd.wr_en && new_ff && !full) begin
         tracked_in = tracked_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff <= '0;
      end else begin
         tracked_ff <= tracked_in;
      end
   end

   // Result register
   assign count_ext = {{OW{1'b0}}, tracked_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_data_ff <= {(RSP_DATA_W_LOCAL - RSP_USED)'(0), count_ext[OW-1:0], reason, allowed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The table never holds more entries than it has cells
   a_tracked_bound: assert property (@(posedge clock) disable iff (reset)
      tracked_ff <= CNT_W'(N))
      else $error("tracked count exceeds table size");

   // At most one scan token is in the cell row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one scan token in flight");

   // A token leaves the row only while the sequencer waits for it
   a_token_exit: assert property (@(posedge clock) disable iff (reset)
      flags_c[N].active |-> state_ff == ST_SCAN)
      else $error("scan token left the row outside the scan phase");

   // A new key with room in the table always finds a free entry
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !scan_flags_ff.found && !full) |-> scan_flags_ff.free_found)
      else $error("no free entry found for a new key");

   // A clear empties the table
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> tracked_ff == '0)
      else $error("table not empty after clear");

endmodule

@@ rtl/fwrl_cell.sv @@
// One table entry of the limiter with its stage of the lookup scan.
module fwrl_cell #(
   parameter int KEY_W    = fwrl_pkg::KEY_WIDTH_DEF,
   parameter int TIME_W   = fwrl_pkg::TIME_WIDTH_DEF,
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   // broadcast item fields
   input  logic [KEY_W-1:0]                key,
   input  logic [TIME_W-1:0]               now,
   // broadcast write
   input  fwrl_pkg::cell_cmd_type          cmd,
   input  logic [IDX_W-1:0]                wr_idx,
   input  logic [KEY_W-1:0]                wr_key,
   input  logic [TIME_W-1:0]               wr_ws,
   input  logic [TIME_W-1:0]               wr_ls,
   input  logic [fwrl_pkg::COUNT_W-1:0]    wr_rc,
   input  logic [fwrl_pkg::COUNT_W-1:0]    wr_tc,
   // scan token from the left neighbor
   input  fwrl_pkg::scan_flags_type        in_flags,
   input  logic [IDX_W-1:0]                in_found_idx,
   input  logic [IDX_W-1:0]                in_free_idx,
   input  logic [IDX_W-1:0]                in_victim_idx,
   input  logic [TIME_W-1:0]               in_best_age,
   input  logic [TIME_W-1:0]               in_ws,
   input  logic [fwrl_pkg::COUNT_W-1:0]    in_rc,
   input  logic [fwrl_pkg::COUNT_W-1:0]    in_tc,
   // scan token to the right neighbor
   output fwrl_pkg::scan_flags_type        out_flags,
   output logic [IDX_W-1:0]                out_found_idx,
   output logic [IDX_W-1:0]                out_free_idx,
   output logic [IDX_W-1:0]                out_victim_idx,
   output logic [TIME_W-1:0]               out_best_age,
   output logic [TIME_W-1:0]               out_ws,
   output logic [fwrl_pkg::COUNT_W-1:0]    out_rc,
   output logic [fwrl_pkg::COUNT_W-1:0]    out_tc
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                         valid_ff;
   logic [KEY_W-1:0]             key_ff;
   logic [TIME_W-1:0]            ws_ff;
   logic [TIME_W-1:0]            ls_ff;
   logic [fwrl_pkg::COUNT_W-1:0] rc_ff;
   logic [fwrl_pkg::COUNT_W-1:0] tc_ff;

   fwrl_pkg::scan_flags_type     flags_ff, flags_in;
   logic [IDX_W-1:0]             found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]             victim_idx_ff, victim_idx_in;
   logic [TIME_W-1:0]            best_age_ff, best_age_in;
   logic [TIME_W-1:0]            tws_ff, tws_in;
   logic [fwrl_pkg::COUNT_W-1:0] trc_ff, trc_in;
   logic [fwrl_pkg::COUNT_W-1:0] ttc_ff, ttc_in;

   logic                         hit;
   logic [TIME_W-1:0]            age;

   assign hit = valid_ff && (key_ff == key);
   assign age = now - ls_ff;

   // Fold this entry into the passing token
   always_comb begin
      flags_in      = in_flags;
      found_idx_in  = in_found_idx;
      free_idx_in   = in_free_idx;
      victim_idx_in = in_victim_idx;
      best_age_in   = in_best_age;
      tws_in        = in_ws;
      trc_in        = in_rc;
      ttc_in        = in_tc;
      if (in_flags.active) begin
         if (!in_flags.found && hit) begin
            flags_in.found = 1'b1;
            found_idx_in   = MY_IDX;
            tws_in         = ws_ff;
            trc_in         = rc_ff;
            ttc_in         = tc_ff;
         end
         if (!in_flags.free_found && !valid_ff) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = MY_IDX;
         end
         if (valid_ff && (!in_flags.victim_valid || age > in_best_age)) begin
            flags_in.victim_valid = 1'b1;
            victim_idx_in         = MY_IDX;
            best_age_in           = age;
         end
      end
   end

   // Hand the token on
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff  <= found_idx_in;
      free_idx_ff   <= free_idx_in;
      victim_idx_ff <= victim_idx_in;
      best_age_ff   <= best_age_in;
      tws_ff        <= tws_in;
      trc_ff        <= trc_in;
      ttc_ff        <= ttc_in;
   end

   // Entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.clear_all) begin
         valid_ff <= 1'b0;
      end else if (cmd.wr_en && wr_idx == MY_IDX) begin
         valid_ff <= 1'b1;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_idx == MY_IDX) begin
         key_ff <= wr_key;
         ws_ff  <= wr_ws;
         ls_ff  <= wr_ls;
         rc_ff  <= wr_rc;
         tc_ff  <= wr_tc;
      end
   end

   assign out_flags      = flags_ff;
   assign out_found_idx  = found_idx_ff;
   assign out_free_idx   = free_idx_ff;
   assign out_victim_idx = victim_idx_ff;
   assign out_best_age   = best_age_ff;
   assign out_ws         = tws_ff;
   assign out_rc         = trc_ff;
   assign out_tc         = ttc_ff;

endmodule

@@ tb/sv/per_key_fixed_window_rate_limiter_tb.sv @@
// Self-checking testbench of the per-key fixed-window rate limiter.
module per_key_fixed_window_rate_limiter_tb;

   localparam int ENTRIES     = fwrl_pkg::MAX_PRINCIPALS_DEF;
   localparam int KW          = fwrl_pkg::KEY_WIDTH_DEF;
   localparam int TW          = fwrl_pkg::TIME_WIDTH_DEF;
   localparam int CW          = fwrl_pkg::COUNT_W;
   localparam int REQ_W       = ((KW + TW + 1 + 2*fwrl_pkg::LIMIT_W + 7)/8)*8;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 300;
   localparam int POOL_SIZE   = 72;
   localparam int HOT_KEYS    = 4;
   localparam int QUIET_ITEMS = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 400;

   typedef struct packed {
      logic                          kind;
      logic [KW-1:0]                 key;
      logic [TW-1:0]                 stamp;
      logic                          tool;
      logic [fwrl_pkg::LIMIT_W-1:0]  req_limit;
      logic [fwrl_pkg::LIMIT_W-1:0]  tool_limit;
   } charge_item_type;

   typedef struct {
      logic                           allowed;
      logic [fwrl_pkg::REASON_W-1:0]  reason;
      logic [fwrl_pkg::OUT_CNT_W-1:0] tracked;
   } verdict_type;

   // Quota table mirror: predicts one verdict per accepted word, checks result words
   class admission_scoreboard;
      logic [fwrl_pkg::WTICK_W-1:0] window_len;
      bit                           live[ENTRIES];
      logic [KW-1:0]                owner[ENTRIES];
      logic [TW-1:0]                window_open[ENTRIES];
      logic [TW-1:0]                seen_at[ENTRIES];
      logic [CW-1:0]                req_used[ENTRIES];
      logic [CW-1:0]                tool_used[ENTRIES];
      verdict_type                  due_verdicts[$];
      int                           accepted;
      int                           errors;

      function new();
         window_len = fwrl_pkg::WINDOW_TICKS_RESET;
         foreach (live[i]) live[i] = 1'b0;
         accepted = 0;
         errors   = 0;
      endfunction

      function void set_window(logic [fwrl_pkg::WTICK_W-1:0] value);
         window_len = value;
      endfunction

      function int occupancy();
         int n;
         n = 0;
         foreach (live[i]) if (live[i]) n++;
         return n;
      endfunction

      function int pending();
         return due_verdicts.size();
      endfunction

      function void predict_verdict(charge_item_type it);
         verdict_type   v;
         int            slot;
         int            victim;
         int            i;
         logic [TW-1:0] age;
         logic [TW-1:0] oldest;
         logic [TW-1:0] elapsed;
         logic [CW:0]   next_req;
         logic [CW:0]   next_tool;
         v.allowed = 1'b1;
         v.reason  = fwrl_pkg::REASON_OK;
         slot      = -1;
         victim    = -1;
         oldest    = '0;
         accepted++;
         if (it.kind == fwrl_pkg::KIND_CLEAR) begin
            foreach (live[j]) live[j] = 1'b0;
         end else if (it.req_limit != 0 || it.tool_limit != 0) begin
            // look up the key
            for (i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && live[i] && owner[i] == it.key) slot = i;
            end
            if (slot < 0) begin
               // evict the stalest entry when full, lowest index on a tie
               if (occupancy() >= ENTRIES) begin
                  for (i = 0; i < ENTRIES; i++) begin
                     age = it.stamp - seen_at[i];
                     if (live[i] && (victim < 0 || age > oldest)) begin
                        victim = i;
                        oldest = age;
                     end
                  end
                  live[victim] = 1'b0;
               end
               for (i = 0; i < ENTRIES; i++) begin
                  if (slot < 0 && !live[i]) slot = i;
               end
               live[slot]        = 1'b1;
               owner[slot]       = it.key;
               window_open[slot] = it.stamp;
               req_used[slot]    = '0;
               tool_used[slot]   = '0;
            end
            // restart an expired window, then charge
            elapsed = it.stamp - window_open[slot];
            if (elapsed >= window_len) begin
               window_open[slot] = it.stamp;
               req_used[slot]    = '0;
               tool_used[slot]   = '0;
            end
            seen_at[slot] = it.stamp;
            next_req  = {1'b0, req_used[slot]} + (CW+1)'(1);
            next_tool = {1'b0, tool_used[slot]} + (CW+1)'(it.tool);
            if (it.req_limit != 0 && next_req > {1'b0, it.req_limit}) begin
               v.allowed = 1'b0;
               v.reason  = fwrl_pkg::REASON_REQ_QUOTA;
            end else if (it.tool && it.tool_limit != 0 && next_tool > {1'b0, it.tool_limit})
            begin
               v.allowed = 1'b0;
               v.reason  = fwrl_pkg::REASON_TOOL_QUOTA;
            end else begin
               req_used[slot]  = next_req[CW] ? fwrl_pkg::COUNT_MAX : next_req[CW-1:0];
               tool_used[slot] = next_tool[CW] ? fwrl_pkg::COUNT_MAX : next_tool[CW-1:0];
            end
         end
         v.tracked = fwrl_pkg::OUT_CNT_W'(occupancy());
         due_verdicts.push_back(v);
      endfunction

      function void mismatch(string field, int want, int got);
         errors++;
         $error("%s: expected %0d, got %0d", field, want, got);
      endfunction

      function void check_verdict(logic [fwrl_pkg::RSP_DATA_W-1:0] word);
         verdict_type want;
         if (due_verdicts.size() == 0) begin
            errors++;
            $error("result word %h with no verdict due", word);
            return;
         end
         want = due_verdicts.pop_front();
         if (word[0] !== want.allowed) mismatch("allowed", want.allowed, word[0]);
         if (word[fwrl_pkg::REASON_W:1] !== want.reason)
            mismatch("reason", want.reason, word[fwrl_pkg::REASON_W:1]);
         if (word[fwrl_pkg::REASON_W+fwrl_pkg::OUT_CNT_W:fwrl_pkg::REASON_W+1] !== want.tracked)
            mismatch("tracked_count", want.tracked,
                     word[fwrl_pkg::REASON_W+fwrl_pkg::OUT_CNT_W:fwrl_pkg::REASON_W+1]);
      endfunction
   endclass

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [0:0]                      req_tuser   = '0;
   // principal_key, now_time, is_tool_call, request_limit, tool_call_limit, zero pad
   logic [REQ_W-1:0]                req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   // allowed, reason, tracked_count, zero pad
   logic [fwrl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [fwrl_pkg::WTICK_W-1:0]    csr_data    = '0;

   bit quiet = 1'b0;
   bit calm  = 1'b0;

   admission_scoreboard scoreboard = new();

   per_key_fixed_window_rate_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 1000000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Sample both handshakes; check results before noting new words
   always @(posedge clock) begin
      charge_item_type taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) scoreboard.check_verdict(rsp_tdata);
         if (req_tvalid && req_tready) begin
            taken.kind       = req_tuser[0];
            taken.key        = req_tdata[31:0];
            taken.stamp      = req_tdata[63:32];
            taken.tool       = req_tdata[64];
            taken.req_limit  = req_tdata[80:65];
            taken.tool_limit = req_tdata[96:81];
            scoreboard.predict_verdict(taken);
         end
      end
   end

   // Result side: random stall bursts, one long hold-off to back up the input
   initial begin
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && scoreboard.accepted >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one word and hold it until taken, then maybe idle a short burst
   task automatic send(input logic kind, input logic [31:0] key, input logic [31:0] stamp,
                       input logic tool, input logic [15:0] req_lim,
                       input logic [15:0] tool_lim);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_W-97){1'b0}}, tool_lim, req_lim, tool, stamp, key};
      do @(posedge clock); while (!req_tready);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every verdict has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   task automatic write_window(input logic [fwrl_pkg::WTICK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scoreboard.set_window(value);
   endtask

   // Mostly tight limits so that refusals are common
   function automatic logic [15:0] draw_limit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 16'($urandom_range(1, 6));
      if (pick < 82) return 16'd0;
      if (pick < 92) return 16'($urandom_range(7, 65535));
      return 16'hFFFF;
   endfunction

   initial begin
      logic [31:0]                  wall;
      logic [31:0]                  stamp;
      logic [31:0]                  key;
      logic [31:0]                  pool[POOL_SIZE];
      logic [fwrl_pkg::WTICK_W-1:0] windows[PHASES];
      int                           p;
      int                           n;
      int                           pick;
      windows = '{fwrl_pkg::WINDOW_TICKS_RESET, 32'd1, 32'hFFFF_FFFF, 32'd40, 32'd1000, 32'd0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset window length
      send(fwrl_pkg::KIND_CHARGE, 32'h0000_1234, 32'd0, 1'b0, 16'd0, 16'd0);
      send(fwrl_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd0, 1'b0, 16'd1, 16'd0);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd0, 1'b0, 16'd1, 16'd0);
      send(fwrl_pkg::KIND_CHARGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'd1);
      send(fwrl_pkg::KIND_CHARGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'd1);
      send(fwrl_pkg::KIND_CHARGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd1, 16'd1);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd59999, 1'b0, 16'd1, 16'd0);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd60000, 1'b0, 16'd1, 16'd0);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd60000, 1'b1, 16'd0, 16'd2);
      send(fwrl_pkg::KIND_CHARGE, 32'd0, 32'd60000, 1'b1, 16'd0, 16'd1);
      send(fwrl_pkg::KIND_CHARGE, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0, 16'd0, 16'd0);
      send(fwrl_pkg::KIND_CLEAR, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0);

      wall = 32'd100000;
      for (p = 0; p < PHASES; p++) begin
         drain();
         if (p != 0) write_window(windows[p] != 0 ? windows[p] : $urandom_range(1, 5000));
         foreach (pool[i]) pool[i] = $urandom();
         if ($urandom_range(0, 2) == 0) wall = 32'hFFFF_FF00;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            if (p == PHASES-1 && n >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            // advance time, mostly in small steps
            pick = $urandom_range(0, 99);
            if (pick < 70) wall = wall + $urandom_range(0, 2);
            else if (pick < 95) wall = wall + $urandom_range(0, 20);
            else wall = wall + $urandom();
            stamp = ($urandom_range(0, 99) < 3) ? $urandom() : wall;
            // walk the pool first to fill the table, then favor a few hot keys
            if (n < POOL_SIZE) begin
               key = pool[n];
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 45) key = pool[$urandom_range(0, HOT_KEYS-1)];
               else if (pick < 90) key = pool[$urandom_range(0, POOL_SIZE-1)];
               else key = $urandom();
            end
            pick = $urandom_range(0, 99);
            if (n >= POOL_SIZE && pick < 2)
               send(fwrl_pkg::KIND_CLEAR, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                    16'($urandom()), 16'($urandom()));
            else if (n >= POOL_SIZE && pick < 5)
               send(fwrl_pkg::KIND_CHARGE, key, stamp, 1'($urandom_range(0, 1)),
                    16'd0, 16'd0);
            else
               send(fwrl_pkg::KIND_CHARGE, key, stamp, 1'($urandom_range(0, 1)),
                    draw_limit(), draw_limit());
         end
      end

      drain();
      repeat (ENTRIES + 8) @(posedge clock);
      if (scoreboard.pending() != 0) begin
         scoreboard.errors++;
         $error("%0d verdicts never arrived", scoreboard.pending());
      end
      if (scoreboard.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
